// ===== design/emr_pkg.sv =====
// Shared codes for the midpoint ellipse rasterizer: operation codes,
// configuration register indexes and the multiplier operand selects.
// No dependencies; every other file of the block but emr_clip imports this package.
`timescale 1ns / 1ps
`default_nettype none

package emr_pkg;

    // Operation field of an input word
    localparam logic OP_START = 1'b0;
    localparam logic OP_STEP  = 1'b1;

    // Configuration register indexes
    localparam int CFG_IDX_BITS = 3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_CLIP_ENABLE = CFG_IDX_BITS'(0);
    localparam logic [CFG_IDX_BITS-1:0] CFG_CLIP_LEFT   = CFG_IDX_BITS'(1);
    localparam logic [CFG_IDX_BITS-1:0] CFG_CLIP_RIGHT  = CFG_IDX_BITS'(2);
    localparam logic [CFG_IDX_BITS-1:0] CFG_CLIP_TOP    = CFG_IDX_BITS'(3);
    localparam logic [CFG_IDX_BITS-1:0] CFG_CLIP_BOTTOM = CFG_IDX_BITS'(4);

    // Operand pairs of the shared multiplier
    typedef enum logic [2:0] {
        MUL_A_SQ,    // radius_x * radius_x
        MUL_B_SQ,    // radius_y * radius_y
        MUL_A2_B,    // a2 * radius_y
        MUL_HX_SQ,   // (2x+1) * (2x+1)
        MUL_YM_SQ,   // (y-1) * (y-1)
        MUL_B2_ACC,  // b2 * accumulator
        MUL_A2_ACC,  // a2 * accumulator
        MUL_A2_B2    // a2 * b2
    } t_mul_sel;

endpackage

`default_nettype wire

// ===== design/emr_mul.sv =====
// Shared multiplier of the ellipse rasterizer: operand select and one
// registered product. Depends on emr_pkg for the operand select codes.
`timescale 1ns / 1ps
`default_nettype none

module emr_mul #(
    parameter int RADIUS_BITS = 11
) (
    input  wire                        i_clk,
    input  emr_pkg::t_mul_sel          i_sel,
    input  wire  [RADIUS_BITS-1:0]     i_rad_x,
    input  wire  [RADIUS_BITS-1:0]     i_rad_y,
    input  wire  [2*RADIUS_BITS-1:0]   i_a2,
    input  wire  [2*RADIUS_BITS-1:0]   i_b2,
    input  wire  [RADIUS_BITS+2:0]     i_hx,
    input  wire  [RADIUS_BITS:0]       i_ym,
    input  wire  [2*RADIUS_BITS+5:0]   i_acc,
    output logic [4*RADIUS_BITS+11:0]  o_prod
);
    import emr_pkg::*;

    localparam int AW = 2 * RADIUS_BITS + 6;
    localparam int PW = 2 * AW;

    logic [AW-1:0] op_a;
    logic [AW-1:0] op_b;

    // Pick the operand pair for this cycle
    always_comb begin
        case (i_sel)
            MUL_A_SQ: begin
                op_a = AW'(i_rad_x);
                op_b = AW'(i_rad_x);
            end
            MUL_B_SQ: begin
                op_a = AW'(i_rad_y);
                op_b = AW'(i_rad_y);
            end
            MUL_A2_B: begin
                op_a = AW'(i_a2);
                op_b = AW'(i_rad_y);
            end
            MUL_HX_SQ: begin
                op_a = AW'(i_hx);
                op_b = AW'(i_hx);
            end
            MUL_YM_SQ: begin
                op_a = AW'(i_ym);
                op_b = AW'(i_ym);
            end
            MUL_B2_ACC: begin
                op_a = AW'(i_b2);
                op_b = i_acc;
            end
            MUL_A2_ACC: begin
                op_a = AW'(i_a2);
                op_b = i_acc;
            end
            MUL_A2_B2: begin
                op_a = AW'(i_a2);
                op_b = AW'(i_b2);
            end
            default: begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    // Register the product
    always_ff @(posedge i_clk) begin
        o_prod <= PW'(op_a * op_b);
    end

endmodule

`default_nettype wire

// ===== design/emr_clip.sv =====
// Clip window test of the ellipse rasterizer for the four mirrored pixels.
// Depends on emr_pkg only by convention; no package items are needed.
`timescale 1ns / 1ps
`default_nettype none

module emr_clip #(
    parameter int COORD_BITS = 16,
    parameter int EXT_BITS   = 18
) (
    input  wire                          i_enable,
    input  wire signed [COORD_BITS-1:0]  i_left,
    input  wire signed [COORD_BITS-1:0]  i_right,
    input  wire signed [COORD_BITS-1:0]  i_top,
    input  wire signed [COORD_BITS-1:0]  i_bottom,
    input  wire signed [EXT_BITS-1:0]    i_right_x,
    input  wire signed [EXT_BITS-1:0]    i_left_x,
    input  wire signed [EXT_BITS-1:0]    i_lower_y,
    input  wire signed [EXT_BITS-1:0]    i_upper_y,
    output logic [3:0]                   o_mask
);
    logic signed [EXT_BITS-1:0] left_e;
    logic signed [EXT_BITS-1:0] right_e;
    logic signed [EXT_BITS-1:0] top_e;
    logic signed [EXT_BITS-1:0] bottom_e;
    logic in_rx;
    logic in_lx;
    logic in_ly;
    logic in_uy;

    // Widen the window bounds to the exact coordinate width
    assign left_e   = EXT_BITS'(i_left);
    assign right_e  = EXT_BITS'(i_right);
    assign top_e    = EXT_BITS'(i_top);
    assign bottom_e = EXT_BITS'(i_bottom);

    // Test each coordinate against its pair of bounds
    assign in_rx = (i_right_x >= left_e) && (i_right_x <= right_e);
    assign in_lx = (i_left_x  >= left_e) && (i_left_x  <= right_e);
    assign in_ly = (i_lower_y >= top_e)  && (i_lower_y <= bottom_e);
    assign in_uy = (i_upper_y >= top_e)  && (i_upper_y <= bottom_e);

    // Combine into the per-pixel mask, all set when clipping is off
    assign o_mask[0] = !i_enable || (in_rx && in_ly);
    assign o_mask[1] = !i_enable || (in_lx && in_ly);
    assign o_mask[2] = !i_enable || (in_rx && in_uy);
    assign o_mask[3] = !i_enable || (in_lx && in_uy);

endmodule

`default_nettype wire

// ===== design/ellipse_midpoint_raster.sv =====
// Midpoint ellipse rasterizer, top level: sequencer, decision datapath, output word.
// Start word: busy through S_A2, S_B2, S_AB, S_D1, S_TRUNC (three shared-multiplier products).
// Step word: busy in S_EMIT, held there while the output word waits, and in S_DEC.
// Point registered in S_EMIT; a region switch adds S_HX to S_P4, S_TRUNC (five products).
// Sync active-low reset clears the sequencer, phase, clip registers and output valid.
// Uses emr_pkg, emr_mul and emr_clip.
`timescale 1ns / 1ps
`default_nettype none

module ellipse_midpoint_raster #(
    parameter int RADIUS_BITS = 11,
    parameter int COORD_BITS  = 16
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    // Input words
    input  wire                                i_valid,
    output logic                               o_stall,
    input  wire                                i_operation,
    input  wire signed [COORD_BITS-1:0]        i_center_x,
    input  wire signed [COORD_BITS-1:0]        i_center_y,
    input  wire        [RADIUS_BITS-1:0]       i_radius_x,
    input  wire        [RADIUS_BITS-1:0]       i_radius_y,
    input  wire        [23:0]                  i_pen_color,
    // Output words
    output logic                               o_valid,
    input  wire                                i_stall,
    output logic signed [COORD_BITS:0]         o_right_x,
    output logic signed [COORD_BITS:0]         o_left_x,
    output logic signed [COORD_BITS:0]         o_lower_y,
    output logic signed [COORD_BITS:0]         o_upper_y,
    output logic        [3:0]                  o_visible_mask,
    output logic        [23:0]                 o_pixel_color,
    output logic                               o_last,
    // Configuration writes
    input  wire                                i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire  [emr_pkg::CFG_IDX_BITS-1:0]   i_cfg_index,
    input  wire  [COORD_BITS-1:0]              i_cfg_data
);
    import emr_pkg::*;

    localparam int XW  = RADIUS_BITS + 2;
    localparam int YW  = RADIUS_BITS + 1;
    localparam int SQW = 2 * RADIUS_BITS;
    localparam int HW  = RADIUS_BITS + 3;
    localparam int ACW = 2 * RADIUS_BITS + 6;
    localparam int PW  = 2 * ACW;
    localparam int SW  = 3 * RADIUS_BITS + 5;
    localparam int DW  = 4 * RADIUS_BITS + 8;
    localparam int EW  = ((COORD_BITS > XW) ? COORD_BITS : XW) + 2;
    localparam int OW  = COORD_BITS + 1;

    typedef enum logic [3:0] {
        S_IDLE, S_A2, S_B2, S_AB, S_D1, S_TRUNC,
        S_HX, S_YM, S_P1, S_P2, S_P3, S_P4, S_EMIT, S_DEC
    } t_state;

    typedef enum logic [1:0] {
        PH_IDLE, PH_R1, PH_R2
    } t_phase;

    t_state r_state;
    t_phase r_phase;

    // Clip window
    logic                          r_clip_en;
    logic signed [COORD_BITS-1:0]  r_clip_left;
    logic signed [COORD_BITS-1:0]  r_clip_right;
    logic signed [COORD_BITS-1:0]  r_clip_top;
    logic signed [COORD_BITS-1:0]  r_clip_bottom;

    // Held ellipse and algorithm terms
    logic signed [COORD_BITS-1:0]  r_cx;
    logic signed [COORD_BITS-1:0]  r_cy;
    logic        [23:0]            r_color;
    logic        [RADIUS_BITS-1:0] r_rad_x;
    logic        [RADIUS_BITS-1:0] r_rad_y;
    logic        [SQW-1:0]         r_a2;
    logic        [SQW-1:0]         r_b2;
    logic        [XW-1:0]          r_off_x;
    logic        [YW-1:0]          r_off_y;
    logic signed [SW-1:0]          r_sx;
    logic signed [SW-1:0]          r_sy;
    logic signed [DW-1:0]          r_dec;
    logic        [ACW-1:0]         r_acc;
    logic                          r_fin;
    logic                          r_diag;

    // Output word
    logic                          r_out_valid;
    logic signed [OW-1:0]          r_right_x;
    logic signed [OW-1:0]          r_left_x;
    logic signed [OW-1:0]          r_lower_y;
    logic signed [OW-1:0]          r_upper_y;
    logic        [3:0]             r_mask;
    logic        [23:0]            r_pixel_color;
    logic                          r_last;

    t_mul_sel                      mul_sel;
    logic        [PW-1:0]          prod;
    logic        [HW-1:0]          hx;
    logic        [YW-1:0]          ym;
    logic signed [EW-1:0]          cx_e;
    logic signed [EW-1:0]          cy_e;
    logic signed [EW-1:0]          ox_e;
    logic signed [EW-1:0]          oy_e;
    logic signed [EW-1:0]          sum_rx;
    logic signed [EW-1:0]          sum_lx;
    logic signed [EW-1:0]          sum_ly;
    logic signed [EW-1:0]          sum_uy;
    logic        [3:0]             mask;
    logic signed [SW-1:0]          two_a2;
    logic signed [SW-1:0]          two_b2;
    logic signed [DW-1:0]          a2_d;
    logic signed [DW-1:0]          b2_d;
    logic signed [DW-1:0]          prod_d;
    logic signed [DW-1:0]          prod4_d;
    logic signed [DW-1:0]          sx_d;
    logic signed [DW-1:0]          sy_d;
    logic signed [DW-1:0]          n_trunc;
    logic signed [DW-1:0]          n_dec_step;
    logic                          dec_neg;
    logic                          dec_pos;
    logic                          fin;
    logic                          diag;
    logic                          out_free;
    logic                          emit_now;
    logic                          in_accept;

    assign o_stall     = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign in_accept   = i_valid && (r_state == S_IDLE);
    assign out_free    = !r_out_valid || !i_stall;
    assign emit_now    = (r_state == S_EMIT) && out_free;

    // Drive the output word
    assign o_valid        = r_out_valid;
    assign o_right_x      = r_right_x;
    assign o_left_x       = r_left_x;
    assign o_lower_y      = r_lower_y;
    assign o_upper_y      = r_upper_y;
    assign o_visible_mask = r_mask;
    assign o_pixel_color  = r_pixel_color;
    assign o_last         = r_last;

    // Region-two setup operands; y-1 is squared, so take its magnitude
    assign hx = {r_off_x, 1'b1};
    assign ym = (r_off_y == '0) ? YW'(1) : (r_off_y - YW'(1));

    // Exact pixel coordinates
    assign cx_e   = EW'(r_cx);
    assign cy_e   = EW'(r_cy);
    assign ox_e   = $signed({{(EW-XW){1'b0}}, r_off_x});
    assign oy_e   = $signed({{(EW-YW){1'b0}}, r_off_y});
    assign sum_rx = cx_e + ox_e;
    assign sum_lx = cx_e - ox_e;
    assign sum_ly = cy_e + oy_e;
    assign sum_uy = cy_e - oy_e;

    // Widened terms for the slope and decision adders
    assign two_a2  = $signed({{(SW-SQW-1){1'b0}}, r_a2, 1'b0});
    assign two_b2  = $signed({{(SW-SQW-1){1'b0}}, r_b2, 1'b0});
    assign a2_d    = $signed({{(DW-SQW){1'b0}}, r_a2});
    assign b2_d    = $signed({{(DW-SQW){1'b0}}, r_b2});
    assign prod_d  = $signed(prod[DW-1:0]);
    assign prod4_d = $signed({prod[DW-3:0], 2'b00});
    assign sx_d    = DW'(r_sx);
    assign sy_d    = DW'(r_sy);

    // Truncate a quarter-unit value toward zero
    assign n_trunc = (r_dec + $signed({{(DW-2){1'b0}}, {2{r_dec[DW-1]}}})) >>> 2;

    // Branch of the current step
    assign dec_neg = r_dec[DW-1];
    assign dec_pos = !r_dec[DW-1] && (r_dec != '0);
    assign diag    = (r_phase == PH_R1) ? !dec_neg : !dec_pos;
    assign fin     = (r_phase == PH_R2) && (r_off_y == '0);

    // Decision update after the offsets and slopes have moved
    always_comb begin
        n_dec_step = r_dec;
        if (r_diag || (r_phase == PH_R1)) begin
            n_dec_step = n_dec_step + sx_d;
        end
        if (r_diag || (r_phase != PH_R1)) begin
            n_dec_step = n_dec_step - sy_d;
        end
        if (r_phase == PH_R1) begin
            n_dec_step = n_dec_step + b2_d;
        end else begin
            n_dec_step = n_dec_step + a2_d;
        end
    end

    // Select the multiplier operands for each sequencer step
    always_comb begin
        case (r_state)
            S_A2:    mul_sel = MUL_A_SQ;
            S_B2:    mul_sel = MUL_B_SQ;
            S_AB:    mul_sel = MUL_A2_B;
            S_HX:    mul_sel = MUL_HX_SQ;
            S_YM:    mul_sel = MUL_YM_SQ;
            S_P1:    mul_sel = MUL_B2_ACC;
            S_P2:    mul_sel = MUL_A2_ACC;
            S_P3:    mul_sel = MUL_A2_B2;
            default: mul_sel = MUL_A_SQ;
        endcase
    end

    emr_mul #(
        .RADIUS_BITS (RADIUS_BITS)
    ) u_mul (
        .i_clk   (i_clk),
        .i_sel   (mul_sel),
        .i_rad_x (r_rad_x),
        .i_rad_y (r_rad_y),
        .i_a2    (r_a2),
        .i_b2    (r_b2),
        .i_hx    (hx),
        .i_ym    (ym),
        .i_acc   (r_acc),
        .o_prod  (prod)
    );

    emr_clip #(
        .COORD_BITS (COORD_BITS),
        .EXT_BITS   (EW)
    ) u_clip (
        .i_enable  (r_clip_en),
        .i_left    (r_clip_left),
        .i_right   (r_clip_right),
        .i_top     (r_clip_top),
        .i_bottom  (r_clip_bottom),
        .i_right_x (sum_rx),
        .i_left_x  (sum_lx),
        .i_lower_y (sum_ly),
        .i_upper_y (sum_uy),
        .o_mask    (mask)
    );

    // Sequencer, datapath registers and output word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_phase       <= PH_IDLE;
            r_out_valid   <= 1'b0;
            r_clip_en     <= 1'b0;
            r_clip_left   <= '0;
            r_clip_right  <= '0;
            r_clip_top    <= '0;
            r_clip_bottom <= '0;
        end else begin
            // Take configuration writes
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_CLIP_ENABLE: r_clip_en     <= i_cfg_data[0];
                    CFG_CLIP_LEFT:   r_clip_left   <= $signed(i_cfg_data);
                    CFG_CLIP_RIGHT:  r_clip_right  <= $signed(i_cfg_data);
                    CFG_CLIP_TOP:    r_clip_top    <= $signed(i_cfg_data);
                    CFG_CLIP_BOTTOM: r_clip_bottom <= $signed(i_cfg_data);
                    default: ;
                endcase
            end

            // Raise the output valid on an emit, drop it once taken
            if (emit_now) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (in_accept) begin
                        if (i_operation == OP_START) begin
                            r_cx    <= i_center_x;
                            r_cy    <= i_center_y;
                            r_color <= i_pen_color;
                            r_rad_x <= i_radius_x;
                            r_rad_y <= i_radius_y;
                            r_off_x <= '0;
                            r_off_y <= YW'(i_radius_y);
                            r_sx    <= '0;
                            r_phase <= PH_R1;
                            r_state <= S_A2;
                        end else if (r_phase != PH_IDLE) begin
                            if ((r_phase == PH_R1) && !(r_sx < r_sy)) begin
                                r_phase <= PH_R2;
                                r_state <= S_HX;
                            end else begin
                                r_state <= S_EMIT;
                            end
                        end
                    end
                end
                S_A2: begin
                    r_state <= S_B2;
                end
                S_B2: begin
                    r_a2    <= prod[SQW-1:0];
                    r_state <= S_AB;
                end
                S_AB: begin
                    r_b2    <= prod[SQW-1:0];
                    r_state <= S_D1;
                end
                S_D1: begin
                    // Region-one start in quarter units: 4*b2 - 4*a2*b + a2
                    r_sy    <= $signed({prod[SW-2:0], 1'b0});
                    r_dec   <= $signed({b2_d[DW-3:0], 2'b00}) - prod4_d + a2_d;
                    r_state <= S_TRUNC;
                end
                S_TRUNC: begin
                    r_dec <= n_trunc;
                    if (r_phase == PH_R2) begin
                        r_state <= S_EMIT;
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                S_HX: begin
                    r_state <= S_YM;
                end
                S_YM: begin
                    r_acc   <= prod[ACW-1:0];
                    r_state <= S_P1;
                end
                S_P1: begin
                    r_acc   <= prod[ACW-1:0];
                    r_state <= S_P2;
                end
                S_P2: begin
                    r_dec   <= prod_d;
                    r_state <= S_P3;
                end
                S_P3: begin
                    r_dec   <= r_dec + prod4_d;
                    r_state <= S_P4;
                end
                S_P4: begin
                    r_dec   <= r_dec - prod4_d;
                    r_state <= S_TRUNC;
                end
                S_EMIT: begin
                    // Hold until the output register is free
                    if (out_free) begin
                        r_right_x     <= sum_rx[OW-1:0];
                        r_left_x      <= sum_lx[OW-1:0];
                        r_lower_y     <= sum_ly[OW-1:0];
                        r_upper_y     <= sum_uy[OW-1:0];
                        r_mask        <= mask;
                        r_pixel_color <= r_color;
                        r_last        <= fin;
                        r_fin         <= fin;
                        r_diag        <= diag;
                        // Advance the offsets and slope terms
                        if ((r_phase == PH_R1) || diag) begin
                            r_off_x <= r_off_x + XW'(1);
                            r_sx    <= r_sx + two_b2;
                        end
                        if ((r_phase == PH_R2) || diag) begin
                            r_off_y <= r_off_y - YW'(1);
                            r_sy    <= r_sy - two_a2;
                        end
                        r_state <= S_DEC;
                    end
                end
                S_DEC: begin
                    r_dec <= n_dec_step;
                    if (r_fin) begin
                        r_phase <= PH_IDLE;
                    end
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== bench/emr_checker.sv =====
// Scoreboard for the midpoint ellipse rasterizer: watches the input, output and
// configuration channels, tracks the ellipse walk and compares every pixel word.
// Depends on emr_pkg for operation codes and configuration register indexes.
`timescale 1ns / 1ps

module emr_checker #(
    parameter int RADIUS_BITS = 11,
    parameter int COORD_BITS  = 16
) (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    // Input channel
    input  wire                               i_in_valid,
    input  wire                               i_in_stall,
    input  wire                               i_operation,
    input  wire signed [COORD_BITS-1:0]       i_center_x,
    input  wire signed [COORD_BITS-1:0]       i_center_y,
    input  wire        [RADIUS_BITS-1:0]      i_radius_x,
    input  wire        [RADIUS_BITS-1:0]      i_radius_y,
    input  wire        [23:0]                 i_pen_color,
    // Output channel
    input  wire                               i_out_valid,
    input  wire                               i_out_stall,
    input  wire        [COORD_BITS:0]         i_right_x,
    input  wire        [COORD_BITS:0]         i_left_x,
    input  wire        [COORD_BITS:0]         i_lower_y,
    input  wire        [COORD_BITS:0]         i_upper_y,
    input  wire        [3:0]                  i_visible_mask,
    input  wire        [23:0]                 i_pixel_color,
    input  wire                               i_last,
    // Configuration channel
    input  wire                               i_cfg_valid,
    input  wire                               i_cfg_ready,
    input  wire  [emr_pkg::CFG_IDX_BITS-1:0]  i_cfg_index,
    input  wire  [COORD_BITS-1:0]             i_cfg_data,
    // Status toward the stimulus side
    output int                                o_errors,
    output int                                o_pending,
    output logic                              o_drawing
);

    import emr_pkg::*;

    typedef enum logic [1:0] {
        ARC_IDLE,
        ARC_SHALLOW,   // x advances every point, y sometimes
        ARC_STEEP      // y advances every point, x sometimes
    } t_arc_phase;

    typedef struct packed {
        logic [COORD_BITS:0] right_x;
        logic [COORD_BITS:0] left_x;
        logic [COORD_BITS:0] lower_y;
        logic [COORD_BITS:0] upper_y;
        logic [3:0]          mask;
        logic [23:0]         color;
        logic                last;
    } t_pixel_quad;

    t_pixel_quad quad_q[$];

    // Ellipse walk state
    t_arc_phase  arc_phase;
    longint      off_x, off_y, slope_x, slope_y, err_term;
    longint      a_sq, b_sq, ctr_x, ctr_y;
    logic [23:0] held_color;

    // Clip window
    logic        clip_on;
    longint      win_left, win_right, win_top, win_bottom;

    int          fails = 0;

    function automatic bit in_window(input longint px, input longint py);
        return !clip_on || (px >= win_left && px <= win_right &&
                            py >= win_top && py <= win_bottom);
    endfunction

    always @(posedge i_clk) begin
        t_pixel_quad want, got;
        longint      a, b, hx, ym, rx, lx, ly, uy;

        if (!i_rst_n) begin
            arc_phase  = ARC_IDLE;
            off_x      = 0;
            off_y      = 0;
            slope_x    = 0;
            slope_y    = 0;
            err_term   = 0;
            a_sq       = 0;
            b_sq       = 0;
            ctr_x      = 0;
            ctr_y      = 0;
            held_color = '0;
            clip_on    = 1'b0;
            win_left   = 0;
            win_right  = 0;
            win_top    = 0;
            win_bottom = 0;
            quad_q.delete();
        end else begin
            // Compare the pixel word leaving the block with the oldest prediction
            if (i_out_valid && !i_out_stall) begin
                got = '{i_right_x, i_left_x, i_lower_y, i_upper_y,
                        i_visible_mask, i_pixel_color, i_last};
                if (quad_q.size() == 0) begin
                    fails++;
                    if (fails <= 10)
                        $display("%0t: pixel word with none predicted: %s%0d %0d %0d %0d",
                                 $time, "rx lx ly uy = ",
                                 $signed(got.right_x), $signed(got.left_x),
                                 $signed(got.lower_y), $signed(got.upper_y));
                end else begin
                    want = quad_q.pop_front();
                    if (got !== want) begin
                        fails++;
                        if (fails <= 10) begin
                            $display("%0t: pixel word mismatch", $time);
                            $display("  expected rx=%0d lx=%0d ly=%0d uy=%0d %s%h %s%h %s%b",
                                     $signed(want.right_x), $signed(want.left_x),
                                     $signed(want.lower_y), $signed(want.upper_y),
                                     "mask=", want.mask, "color=", want.color,
                                     "last=", want.last);
                            $display("  actual   rx=%0d lx=%0d ly=%0d uy=%0d %s%h %s%h %s%b",
                                     $signed(got.right_x), $signed(got.left_x),
                                     $signed(got.lower_y), $signed(got.upper_y),
                                     "mask=", got.mask, "color=", got.color,
                                     "last=", got.last);
                        end
                    end
                end
            end

            // Track clip register writes
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_CLIP_ENABLE: clip_on    = i_cfg_data[0];
                    CFG_CLIP_LEFT:   win_left   = signed'(i_cfg_data);
                    CFG_CLIP_RIGHT:  win_right  = signed'(i_cfg_data);
                    CFG_CLIP_TOP:    win_top    = signed'(i_cfg_data);
                    CFG_CLIP_BOTTOM: win_bottom = signed'(i_cfg_data);
                    default: ;
                endcase
            end

            // Advance the walk on every accepted input word
            if (i_in_valid && !i_in_stall) begin
                if (i_operation == OP_START) begin
                    // Latch the ellipse and set up the shallow-region decision in quarter units
                    a          = i_radius_x;
                    b          = i_radius_y;
                    ctr_x      = i_center_x;
                    ctr_y      = i_center_y;
                    held_color = i_pen_color;
                    a_sq       = a * a;
                    b_sq       = b * b;
                    off_x      = 0;
                    off_y      = b;
                    slope_x    = 0;
                    slope_y    = 2 * a_sq * b;
                    err_term   = (4 * b_sq - 4 * a_sq * b + a_sq) / 4;
                    arc_phase  = ARC_SHALLOW;
                end else if (arc_phase != ARC_IDLE) begin
                    // Switch to the steep region once the x slope catches up
                    if (arc_phase == ARC_SHALLOW && slope_x >= slope_y) begin
                        hx        = 2 * off_x + 1;
                        ym        = off_y - 1;
                        err_term  = (b_sq * hx * hx + 4 * a_sq * ym * ym - 4 * a_sq * b_sq) / 4;
                        arc_phase = ARC_STEEP;
                    end

                    rx = ctr_x + off_x;
                    lx = ctr_x - off_x;
                    ly = ctr_y + off_y;
                    uy = ctr_y - off_y;
                    want.right_x = rx[COORD_BITS:0];
                    want.left_x  = lx[COORD_BITS:0];
                    want.lower_y = ly[COORD_BITS:0];
                    want.upper_y = uy[COORD_BITS:0];
                    // Clip on the exact sums, before any wrap
                    want.mask    = {in_window(lx, uy), in_window(rx, uy),
                                    in_window(lx, ly), in_window(rx, ly)};
                    want.color   = held_color;
                    want.last    = (arc_phase == ARC_STEEP && off_y == 0);
                    quad_q.push_back(want);

                    if (arc_phase == ARC_SHALLOW) begin
                        off_x++;
                        slope_x += 2 * b_sq;
                        if (err_term < 0) begin
                            err_term += slope_x + b_sq;
                        end else begin
                            off_y--;
                            slope_y  -= 2 * a_sq;
                            err_term += slope_x - slope_y + b_sq;
                        end
                    end else begin
                        off_y--;
                        slope_y -= 2 * a_sq;
                        if (err_term > 0) begin
                            err_term += a_sq - slope_y;
                        end else begin
                            off_x++;
                            slope_x  += 2 * b_sq;
                            err_term += slope_x - slope_y + a_sq;
                        end
                        if (want.last)
                            arc_phase = ARC_IDLE;
                    end
                end
            end
        end

        o_errors  <= fails;
        o_pending <= quad_q.size();
        o_drawing <= (arc_phase != ARC_IDLE);
    end

endmodule

// ===== bench/ellipse_midpoint_raster_tb.sv =====
// Testbench top for the midpoint ellipse rasterizer: clock, reset, stimulus,
// clip programming, idle patterns, watchdog and verdict.
// Depends on emr_pkg, ellipse_midpoint_raster and emr_checker.
`timescale 1ns / 1ps

module ellipse_midpoint_raster_tb;

    import emr_pkg::*;

    localparam int RB            = 11;
    localparam int CB            = 16;
    localparam int STALL_LIMIT   = 1000;
    localparam int SETTLE_CYCLES = 24;
    localparam int PHASE_WORDS   = 138;
    localparam int FULL_ARC      = 1 << 16;

    logic                         clk;
    logic                         rst_n;
    logic                         in_valid;
    logic                         in_stall;
    logic                         in_op;
    logic signed [CB-1:0]         in_cx;
    logic signed [CB-1:0]         in_cy;
    logic        [RB-1:0]         in_rx;
    logic        [RB-1:0]         in_ry;
    logic        [23:0]           in_color;
    logic                         out_valid;
    logic                         out_stall = 1'b0;
    logic signed [CB:0]           out_right_x;
    logic signed [CB:0]           out_left_x;
    logic signed [CB:0]           out_lower_y;
    logic signed [CB:0]           out_upper_y;
    logic        [3:0]            out_mask;
    logic        [23:0]           out_color;
    logic                         out_last;
    logic                         cfg_valid;
    logic                         cfg_ready;
    logic        [CFG_IDX_BITS-1:0] cfg_index;
    logic        [CB-1:0]         cfg_data;

    int                           errors;
    int                           pending;
    logic                         drawing;

    int sender_idle_pct = 0;
    int recv_idle_pct   = 0;
    int items           = 0;
    int quiet_cycles    = 0;

    ellipse_midpoint_raster #(
        .RADIUS_BITS (RB),
        .COORD_BITS  (CB)
    ) u_top (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_valid        (in_valid),
        .o_stall        (in_stall),
        .i_operation    (in_op),
        .i_center_x     (in_cx),
        .i_center_y     (in_cy),
        .i_radius_x     (in_rx),
        .i_radius_y     (in_ry),
        .i_pen_color    (in_color),
        .o_valid        (out_valid),
        .i_stall        (out_stall),
        .o_right_x      (out_right_x),
        .o_left_x       (out_left_x),
        .o_lower_y      (out_lower_y),
        .o_upper_y      (out_upper_y),
        .o_visible_mask (out_mask),
        .o_pixel_color  (out_color),
        .o_last         (out_last),
        .i_cfg_valid    (cfg_valid),
        .o_cfg_ready    (cfg_ready),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data)
    );

    emr_checker #(
        .RADIUS_BITS (RB),
        .COORD_BITS  (CB)
    ) u_check (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .i_in_stall     (in_stall),
        .i_operation    (in_op),
        .i_center_x     (in_cx),
        .i_center_y     (in_cy),
        .i_radius_x     (in_rx),
        .i_radius_y     (in_ry),
        .i_pen_color    (in_color),
        .i_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .i_right_x      (out_right_x),
        .i_left_x       (out_left_x),
        .i_lower_y      (out_lower_y),
        .i_upper_y      (out_upper_y),
        .i_visible_mask (out_mask),
        .i_pixel_color  (out_color),
        .i_last         (out_last),
        .i_cfg_valid    (cfg_valid),
        .i_cfg_ready    (cfg_ready),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data),
        .o_errors       (errors),
        .o_pending      (pending),
        .o_drawing      (drawing)
    );

    // 100 MHz clock
    always begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Stall the pixel side at random
    always @(negedge clk) begin
        out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end

    // Abort when no word moves on any channel for too long
    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
            (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Offer one input word after a random gap and hold it until accepted
    task automatic put_word(input logic op, input logic [CB-1:0] cx, input logic [CB-1:0] cy,
                            input logic [RB-1:0] rx, input logic [RB-1:0] ry,
                            input logic [23:0] color);
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_op    <= op;
        in_cx    <= cx;
        in_cy    <= cy;
        in_rx    <= rx;
        in_ry    <= ry;
        in_color <= color;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic start_arc(input logic [CB-1:0] cx, input logic [CB-1:0] cy,
                             input logic [RB-1:0] rx, input logic [RB-1:0] ry,
                             input logic [23:0] color);
        items++;
        put_word(OP_START, cx, cy, rx, ry, color);
    endtask

    // Step with junk in the unused fields; steps while idle are not counted
    task automatic step_arc();
        if (drawing)
            items++;
        put_word(OP_STEP, CB'($urandom), CB'($urandom), RB'($urandom), RB'($urandom),
                 24'($urandom));
    endtask

    task automatic trace_arc(input int max_steps);
        for (int k = 0; k < max_steps && drawing; k++)
            step_arc();
    endtask

    // Drop valid, drain every predicted word, then let the sequencer go quiet
    task automatic settle();
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [CB-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic program_clip(input logic en, input logic [CB-1:0] left,
                                input logic [CB-1:0] right, input logic [CB-1:0] top,
                                input logic [CB-1:0] bottom);
        write_reg(CFG_CLIP_ENABLE, CB'(en));
        write_reg(CFG_CLIP_LEFT, left);
        write_reg(CFG_CLIP_RIGHT, right);
        write_reg(CFG_CLIP_TOP, top);
        write_reg(CFG_CLIP_BOTTOM, bottom);
        cfg_valid <= 1'b0;
    endtask

    // Mostly near the origin, some anywhere, some hugging the extremes
    function automatic logic [CB-1:0] pick_coord();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return CB'(int'($urandom_range(0, 80)) - 40);
        else if (roll < 85)
            return CB'($urandom);
        else if (roll < 93)
            return CB'(32767 - int'($urandom_range(0, 40)));
        else
            return CB'(-32768 + int'($urandom_range(0, 40)));
    endfunction

    // Small radii keep whole ellipses short; a few are near full scale
    function automatic logic [RB-1:0] pick_radius();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 70)
            return RB'($urandom_range(0, 12));
        else if (roll < 95)
            return RB'($urandom_range(13, 60));
        else
            return RB'($urandom_range(1900, 2047));
    endfunction

    // Whole ellipses with random content, some cut short, some stray steps
    task automatic run_random(input int target);
        int          first;
        int          roll;
        logic [RB-1:0] rx;
        logic [RB-1:0] ry;
        first = items;
        while (items - first < target) begin
            roll = $urandom_range(0, 99);
            rx   = pick_radius();
            ry   = pick_radius();
            start_arc(pick_coord(), pick_coord(), rx, ry, 24'($urandom));
            if (rx > 60 || ry > 60)
                trace_arc($urandom_range(5, 40));
            else if (roll < 10)
                trace_arc($urandom_range(0, 6));
            else
                trace_arc(FULL_ARC);
            if (roll >= 92)
                repeat ($urandom_range(1, 3)) step_arc();
        end
    endtask

    initial begin
        int col;

        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_op     = OP_START;
        in_cx     = '0;
        in_cy     = '0;
        in_rx     = '0;
        in_ry     = '0;
        in_color  = '0;
        cfg_valid = 1'b0;
        cfg_index = CFG_CLIP_ENABLE;
        cfg_data  = '0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        sender_idle_pct = 35;
        recv_idle_pct   = 80;

        // Directed: idle step, degenerate radii, field extremes, restart mid-ellipse
        step_arc();
        start_arc(16'sh7fff, 16'sh8000, 11'h7ff, 11'h000, 24'hffffff);
        trace_arc(1);
        step_arc();
        start_arc(16'sh8000, 16'sh7fff, 11'h000, 11'h000, 24'h000000);
        trace_arc(1);
        start_arc(16'sh0000, 16'sh0000, 11'h000, 11'h7ff, 24'ha5a5a5);
        trace_arc(3);
        start_arc(16'sd100, -16'sd100, 11'd3, 11'd2, 24'h5a5a5a);
        trace_arc(FULL_ARC);
        start_arc(16'sh7fff, 16'sh7fff, 11'h7ff, 11'h7ff, 24'h123456);
        trace_arc(4);
        start_arc(-16'sd5, 16'sd7, 11'd1, 11'd1, 24'hc3c3c3);
        trace_arc(FULL_ARC);

        // Random phases, each under its own clip window; the idle pattern changes every two phases
        for (int ph = 0; ph < 6; ph++) begin
            settle();
            case (ph)
                0: program_clip(1'b0, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff);
                1: program_clip(1'b1, CB'(-int'($urandom_range(0, 30))),
                                CB'($urandom_range(0, 30)),
                                CB'(-int'($urandom_range(0, 30))),
                                CB'($urandom_range(0, 30)));
                2: program_clip(1'b1, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff);
                3: begin
                    col = int'($urandom_range(0, 20)) - 10;
                    program_clip(1'b1, CB'(col), CB'(col), 16'h8000, 16'h7fff);
                end
                4: program_clip(1'b0, CB'($urandom), CB'($urandom), CB'($urandom),
                                CB'($urandom));
                default: program_clip(1'b1, 16'sd20, -16'sd20, -16'sd20, 16'sd20);
            endcase
            if (ph < 2) begin
                sender_idle_pct = 35;
                recv_idle_pct   = 80;
            end else if (ph < 4) begin
                sender_idle_pct = 80;
                recv_idle_pct   = 35;
            end else begin
                sender_idle_pct = 0;
                recv_idle_pct   = 0;
            end
            run_random(PHASE_WORDS);
        end

        settle();
        if (errors == 0 && pending == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
